[src/hdvc_pkg.sv]
// Shared types and constants of the hysteresis dosing valve controller.
// No dependencies; every other source file refers to this package by scoped name.
package hdvc_pkg;

	// Band controller state
	typedef enum logic [1:0] {
		BAND_CORRECT = 2'd0,
		BAND_LOW     = 2'd1,
		BAND_HIGH    = 2'd2
	} band_t;

	// Reported mode code for manual operation
	localparam logic [1:0] MODE_MANUAL = 2'd3;

	// Manual valve command codes; any other code keeps the present drive
	localparam logic [1:0] CMD_CLOSE = 2'd0;
	localparam logic [1:0] CMD_OPEN  = 2'd1;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HYST_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_MS   = 3'd4;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic [13:0] LOW_LIMIT_RST  = 14'd5000;
	localparam logic [13:0] HIGH_LIMIT_RST = 14'd7000;
	localparam logic [10:0] HYST_WIDTH_RST = 11'd250;
	localparam logic [15:0] OPEN_MS_RST    = 16'd1000;
	localparam logic [15:0] CLOSE_MS_RST   = 16'd2000;

	typedef struct packed {
		logic [13:0] low_limit;
		logic [13:0] high_limit;
		logic [10:0] hyst_width;
		logic [15:0] open_ms;
		logic [15:0] close_ms;
	} cfg_t;

	typedef struct packed {
		logic [13:0] ph_value;
		logic        pump_on;
		logic        sensor_error;
		logic        alkali_tank_low;
		logic        acid_tank_low;
		logic        manual_request;
		logic        link_up;
		logic [1:0]  manual_raise_cmd;
		logic [1:0]  manual_lower_cmd;
	} in_item_t;

	typedef struct packed {
		logic       raise_valve_on;
		logic       lower_valve_on;
		logic [1:0] control_mode;
		logic       pulse_open_phase;
	} out_item_t;

endpackage

[src/hysteresis_dosing_valve_controller_top.sv]
// Top level of the hysteresis dosing valve controller: handshakes, input and result registers.
// Depends on hdvc_pkg, hdvc_cfg_regs and hdvc_core.
//
// Usage:
//   One input transfer per millisecond tick carries the sensed value in milli-pH and the
//   status flags. Each tick gives exactly one result transfer with both valve drives, the
//   control mode and the pulse phase as they stand after that tick.
//   The input channel (in_valid/in_ready) loads an input register; the tick is then
//   evaluated and written to the result register (out_valid/out_ready) once that
//   register is free or being emptied. One tick per cycle passes while the receiver
//   takes results, set by the single evaluation stage between the two registers. The
//   input register keeps accepting while a result waits, so a stalled receiver costs
//   one held tick before in_ready drops; in_ready returns with out_ready.
//   The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) takes a write
//   every cycle; write it only while no tick is in flight.
//   Reset (arst_n low) restores the default limits and timings, auto mode, correct band,
//   both valves closed and the pulse timer stopped; both registers are emptied.
module hysteresis_dosing_valve_controller_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// Tick input channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [13:0]                      ph_value,
	input  logic                             pump_on,
	input  logic                             sensor_error,
	input  logic                             alkali_tank_low,
	input  logic                             acid_tank_low,
	input  logic                             manual_request,
	input  logic                             link_up,
	input  logic [1:0]                       manual_raise_cmd,
	input  logic [1:0]                       manual_lower_cmd,
	// Result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             raise_valve_on,
	output logic                             lower_valve_on,
	output logic [1:0]                       control_mode,
	output logic                             pulse_open_phase,
	// Configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hdvc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hdvc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	hdvc_pkg::cfg_t      cfg;
	hdvc_pkg::in_item_t  item_in, item_s1;
	hdvc_pkg::out_item_t result_d, result_q;
	logic                valid_s1;
	logic                out_valid_q;
	logic                step_en;

	// Gather the tick payload
	always_comb begin
		item_in.ph_value         = ph_value;
		item_in.pump_on          = pump_on;
		item_in.sensor_error     = sensor_error;
		item_in.alkali_tank_low  = alkali_tank_low;
		item_in.acid_tank_low    = acid_tank_low;
		item_in.manual_request   = manual_request;
		item_in.link_up          = link_up;
		item_in.manual_raise_cmd = manual_raise_cmd;
		item_in.manual_lower_cmd = manual_lower_cmd;
	end

	// Advance a held tick when the result register is free or being emptied
	assign step_en  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_en;

	hdvc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hdvc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.cfg     (cfg),
		.item    (item_s1),
		.result  (result_d)
	);

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (step_en) begin
			result_q <= result_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign raise_valve_on   = result_q.raise_valve_on;
	assign lower_valve_on   = result_q.lower_valve_on;
	assign control_mode     = result_q.control_mode;
	assign pulse_open_phase = result_q.pulse_open_phase;

`ifndef SYNTHESIS
	// Manual mode never reports an open pulse phase
	a_manual_no_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (control_mode == hdvc_pkg::MODE_MANUAL) |-> !pulse_open_phase)
		else $error("pulse phase open in manual mode");

	// Correct band keeps both valves closed
	a_correct_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (control_mode == hdvc_pkg::BAND_CORRECT)
		|-> !raise_valve_on && !lower_valve_on)
		else $error("valve open in correct band");

	// Auto mode never opens both valves together
	a_auto_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (control_mode != hdvc_pkg::MODE_MANUAL)
		|-> !(raise_valve_on && lower_valve_on))
		else $error("both valves open in auto mode");

	// Input stalls only when a tick is held behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a held result");
`endif

endmodule

[src/hdvc_cfg_regs.sv]
// Configuration register file of the dosing valve controller.
// Depends on hdvc_pkg for register indexes, reset values and the cfg_t bundle.
module hdvc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hdvc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hdvc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output hdvc_pkg::cfg_t                   cfg
);

	hdvc_pkg::cfg_t cfg_q;

	// Always take a write; writes to unknown indexes are dropped
	assign cfg_ready = 1'b1;

	// Capture one register per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_limit  <= hdvc_pkg::LOW_LIMIT_RST;
			cfg_q.high_limit <= hdvc_pkg::HIGH_LIMIT_RST;
			cfg_q.hyst_width <= hdvc_pkg::HYST_WIDTH_RST;
			cfg_q.open_ms    <= hdvc_pkg::OPEN_MS_RST;
			cfg_q.close_ms   <= hdvc_pkg::CLOSE_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hdvc_pkg::REG_LOW_LIMIT:  cfg_q.low_limit  <= cfg_data[13:0];
				hdvc_pkg::REG_HIGH_LIMIT: cfg_q.high_limit <= cfg_data[13:0];
				hdvc_pkg::REG_HYST_WIDTH: cfg_q.hyst_width <= cfg_data[10:0];
				hdvc_pkg::REG_OPEN_MS:    cfg_q.open_ms    <= cfg_data;
				hdvc_pkg::REG_CLOSE_MS:   cfg_q.close_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/hdvc_core.sv]
// Band controller, pulse timer and manual override state of the dosing controller.
// Depends on hdvc_pkg; advances its state once per step_en and returns the result.
module hdvc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  hdvc_pkg::cfg_t       cfg,
	input  hdvc_pkg::in_item_t   item,
	output hdvc_pkg::out_item_t  result
);

	hdvc_pkg::band_t band_q, band_d;
	logic        manual_q, manual_d;
	logic        phase_q, phase_d;
	logic [15:0] timer_q, timer_d;
	logic        run_q, run_d;
	logic        exp_q, exp_d;
	logic        raise_q, raise_d;
	logic        lower_q, lower_d;

	// Thresholds compared in 15 bits so that a negative low edge never fires
	logic [14:0] ph_w, half_w, lo_w, hi_w, ph_plus_half, lo_plus_half, hi_plus_half;
	logic        low_enter, low_leave, high_enter, high_leave;

	assign ph_w         = {1'b0, item.ph_value};
	assign half_w       = {5'b0, cfg.hyst_width[10:1]};
	assign lo_w         = {1'b0, cfg.low_limit};
	assign hi_w         = {1'b0, cfg.high_limit};
	assign ph_plus_half = ph_w + half_w;
	assign lo_plus_half = lo_w + half_w;
	assign hi_plus_half = hi_w + half_w;

	assign low_enter  = (ph_plus_half < lo_w) && item.pump_on && !item.sensor_error
		&& !item.alkali_tank_low;
	assign high_enter = (ph_w > hi_plus_half) && item.pump_on && !item.sensor_error
		&& !item.acid_tank_low;
	assign low_leave  = (ph_w > lo_plus_half) || !item.pump_on || item.sensor_error
		|| item.alkali_tank_low;
	assign high_leave = (ph_plus_half < hi_w) || !item.pump_on || item.sensor_error
		|| item.acid_tank_low;

	// Next state: timer first, then mode logic
	always_comb begin
		band_d   = band_q;
		manual_d = manual_q;
		phase_d  = phase_q;
		timer_d  = timer_q;
		run_d    = run_q;
		exp_d    = exp_q;
		raise_d  = raise_q;
		lower_d  = lower_q;

		// Count down; stop and flag expiry at one or below
		if (run_q) begin
			if (timer_q <= 16'd1) begin
				timer_d = 16'd0;
				run_d   = 1'b0;
				exp_d   = 1'b1;
			end else begin
				timer_d = timer_q - 16'd1;
			end
		end

		priority if (manual_q) begin
			if (!item.manual_request || !item.link_up) begin
				// Leave manual and close everything
				manual_d = 1'b0;
				band_d   = hdvc_pkg::BAND_CORRECT;
				phase_d  = 1'b0;
				timer_d  = 16'd0;
				run_d    = 1'b0;
				exp_d    = 1'b0;
				raise_d  = 1'b0;
				lower_d  = 1'b0;
			end else begin
				if (item.manual_raise_cmd == hdvc_pkg::CMD_CLOSE) raise_d = 1'b0;
				if (item.manual_raise_cmd == hdvc_pkg::CMD_OPEN)  raise_d = 1'b1;
				if (item.manual_lower_cmd == hdvc_pkg::CMD_CLOSE) lower_d = 1'b0;
				if (item.manual_lower_cmd == hdvc_pkg::CMD_OPEN)  lower_d = 1'b1;
			end
		end else if (item.manual_request) begin
			// Enter manual and close everything
			manual_d = 1'b1;
			band_d   = hdvc_pkg::BAND_CORRECT;
			phase_d  = 1'b0;
			timer_d  = 16'd0;
			run_d    = 1'b0;
			exp_d    = 1'b0;
			raise_d  = 1'b0;
			lower_d  = 1'b0;
		end else begin
			unique case (band_q)
				hdvc_pkg::BAND_LOW: begin
					if (low_leave) begin
						band_d  = hdvc_pkg::BAND_CORRECT;
						phase_d = 1'b0;
						timer_d = 16'd0;
						run_d   = 1'b0;
						exp_d   = 1'b0;
						raise_d = 1'b0;
						lower_d = 1'b0;
					end else if (exp_d) begin
						// Toggle the raise valve pulse phase
						exp_d   = 1'b0;
						run_d   = 1'b1;
						timer_d = phase_q ? cfg.close_ms : cfg.open_ms;
						raise_d = !phase_q;
						phase_d = !phase_q;
					end
				end
				hdvc_pkg::BAND_HIGH: begin
					if (high_leave) begin
						band_d  = hdvc_pkg::BAND_CORRECT;
						phase_d = 1'b0;
						timer_d = 16'd0;
						run_d   = 1'b0;
						exp_d   = 1'b0;
						raise_d = 1'b0;
						lower_d = 1'b0;
					end else if (exp_d) begin
						// Toggle the lower valve pulse phase
						exp_d   = 1'b0;
						run_d   = 1'b1;
						timer_d = phase_q ? cfg.close_ms : cfg.open_ms;
						lower_d = !phase_q;
						phase_d = !phase_q;
					end
				end
				default: begin
					// Correct band: high entry wins over low entry
					band_d = hdvc_pkg::BAND_CORRECT;
					if (low_enter) begin
						exp_d  = 1'b1;
						band_d = hdvc_pkg::BAND_LOW;
					end
					if (high_enter) begin
						exp_d  = 1'b1;
						band_d = hdvc_pkg::BAND_HIGH;
					end
				end
			endcase
		end
	end

	// Outputs show the state after the tick
	always_comb begin
		result.raise_valve_on   = raise_d;
		result.lower_valve_on   = lower_d;
		result.control_mode     = manual_d ? hdvc_pkg::MODE_MANUAL : band_d;
		result.pulse_open_phase = manual_d ? 1'b0 : phase_d;
	end

	// Hold state between steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q   <= hdvc_pkg::BAND_CORRECT;
			manual_q <= 1'b0;
			phase_q  <= 1'b0;
			timer_q  <= 16'd0;
			run_q    <= 1'b0;
			exp_q    <= 1'b0;
			raise_q  <= 1'b0;
			lower_q  <= 1'b0;
		end else if (step_en) begin
			band_q   <= band_d;
			manual_q <= manual_d;
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			run_q    <= run_d;
			exp_q    <= exp_d;
			raise_q  <= raise_d;
			lower_q  <= lower_d;
		end
	end

endmodule

[tb/hdvc_valve_checker.sv]
`timescale 1ns / 1ps
// Result checker for the dosing valve controller: predicts one result per tick transfer
// and compares each result transfer against the oldest prediction. Depends on hdvc_pkg.
module hdvc_valve_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  hdvc_pkg::in_item_t              tick,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  hdvc_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [hdvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hdvc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending
);

	// shadow of the configuration and the controller state
	hdvc_pkg::cfg_t    dose_cfg;
	logic              man_mode;
	hdvc_pkg::band_t   band;
	logic              phase_open;
	logic [15:0]       pulse_cnt;
	logic              cnt_run;
	logic              cnt_done;
	logic              raise_q;
	logic              lower_q;

	hdvc_pkg::out_item_t expected_valves[$];
	hdvc_pkg::out_item_t want;
	logic                bad;
	int                  mismatches = 0;
	int                  valve_results = 0;

	assign fail_count = mismatches;

	// close both valves and drop back to the correct band
	function automatic void shut_valves();
		band       = hdvc_pkg::BAND_CORRECT;
		phase_open = 1'b0;
		pulse_cnt  = 16'd0;
		cnt_run    = 1'b0;
		cnt_done   = 1'b0;
		raise_q    = 1'b0;
		lower_q    = 1'b0;
	endfunction

	// advance the open/closed pulse of the active valve once its interval has run out
	function automatic logic pulse_drive(input logic drive);
		logic nd;
		nd = drive;
		if (cnt_done) begin
			cnt_done = 1'b0;
			cnt_run  = 1'b1;
			if (!phase_open) begin
				pulse_cnt  = dose_cfg.open_ms;
				nd         = 1'b1;
				phase_open = 1'b1;
			end else begin
				pulse_cnt  = dose_cfg.close_ms;
				nd         = 1'b0;
				phase_open = 1'b0;
			end
		end
		return nd;
	endfunction

	// one millisecond tick: timer first, then mode and band logic
	function automatic hdvc_pkg::out_item_t dose_tick(input hdvc_pkg::in_item_t t);
		int                  ph;
		int                  half;
		int                  lo;
		int                  hi;
		hdvc_pkg::out_item_t r;
		ph   = int'(t.ph_value);
		half = int'(dose_cfg.hyst_width >> 1);
		lo   = int'(dose_cfg.low_limit);
		hi   = int'(dose_cfg.high_limit);

		if (cnt_run) begin
			if (pulse_cnt <= 16'd1) begin
				pulse_cnt = 16'd0;
				cnt_run   = 1'b0;
				cnt_done  = 1'b1;
			end else begin
				pulse_cnt = pulse_cnt - 16'd1;
			end
		end

		if (man_mode) begin
			if (!t.manual_request || !t.link_up) begin
				man_mode = 1'b0;
				shut_valves();
			end else begin
				if (t.manual_raise_cmd == hdvc_pkg::CMD_CLOSE) raise_q = 1'b0;
				else if (t.manual_raise_cmd == hdvc_pkg::CMD_OPEN) raise_q = 1'b1;
				if (t.manual_lower_cmd == hdvc_pkg::CMD_CLOSE) lower_q = 1'b0;
				else if (t.manual_lower_cmd == hdvc_pkg::CMD_OPEN) lower_q = 1'b1;
			end
		end else if (t.manual_request) begin
			man_mode = 1'b1;
			shut_valves();
		end else if (band == hdvc_pkg::BAND_LOW) begin
			if (ph > lo + half || !t.pump_on || t.sensor_error || t.alkali_tank_low)
				shut_valves();
			else
				raise_q = pulse_drive(raise_q);
		end else if (band == hdvc_pkg::BAND_HIGH) begin
			if (ph < hi - half || !t.pump_on || t.sensor_error || t.acid_tank_low)
				shut_valves();
			else
				lower_q = pulse_drive(lower_q);
		end else begin
			// high entry is checked last so that it wins a tie
			if (ph < lo - half && t.pump_on && !t.sensor_error && !t.alkali_tank_low) begin
				cnt_done = 1'b1;
				band     = hdvc_pkg::BAND_LOW;
			end
			if (ph > hi + half && t.pump_on && !t.sensor_error && !t.acid_tank_low) begin
				cnt_done = 1'b1;
				band     = hdvc_pkg::BAND_HIGH;
			end
		end

		r.raise_valve_on   = raise_q;
		r.lower_valve_on   = lower_q;
		r.control_mode     = man_mode ? hdvc_pkg::MODE_MANUAL : band;
		r.pulse_open_phase = man_mode ? 1'b0 : phase_open;
		return r;
	endfunction

	// watch the three channels: compare results, then predict for the new tick
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dose_cfg.low_limit  = hdvc_pkg::LOW_LIMIT_RST;
			dose_cfg.high_limit = hdvc_pkg::HIGH_LIMIT_RST;
			dose_cfg.hyst_width = hdvc_pkg::HYST_WIDTH_RST;
			dose_cfg.open_ms    = hdvc_pkg::OPEN_MS_RST;
			dose_cfg.close_ms   = hdvc_pkg::CLOSE_MS_RST;
			man_mode = 1'b0;
			shut_valves();
			expected_valves.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				valve_results++;
				if (expected_valves.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result %0d arrived with no tick outstanding",
							$time, valve_results);
				end else begin
					want = expected_valves.pop_front();
					bad  = (result.raise_valve_on !== want.raise_valve_on) ||
						(result.lower_valve_on !== want.lower_valve_on) ||
						(result.control_mode !== want.control_mode) ||
						(result.pulse_open_phase !== want.pulse_open_phase);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: result %0d expected raise %b lower %b mode %0d open %b, ",
								$time, valve_results, want.raise_valve_on,
								want.lower_valve_on, want.control_mode,
								want.pulse_open_phase);
							$display("got raise %b lower %b mode %0d open %b",
								result.raise_valve_on, result.lower_valve_on,
								result.control_mode, result.pulse_open_phase);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hdvc_pkg::REG_LOW_LIMIT:  dose_cfg.low_limit  = cfg_data[13:0];
					hdvc_pkg::REG_HIGH_LIMIT: dose_cfg.high_limit = cfg_data[13:0];
					hdvc_pkg::REG_HYST_WIDTH: dose_cfg.hyst_width = cfg_data[10:0];
					hdvc_pkg::REG_OPEN_MS:    dose_cfg.open_ms    = cfg_data;
					hdvc_pkg::REG_CLOSE_MS:   dose_cfg.close_ms   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_valves.push_back(dose_tick(tick));
			pending <= expected_valves.size();
		end
	end

endmodule

[tb/hysteresis_dosing_valve_controller_top_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the dosing valve controller: clock, reset, tick and settings stimulus,
// random back-pressure and the verdict. Depends on hdvc_pkg, the block and hdvc_valve_checker.
module hysteresis_dosing_valve_controller_top_tb;

	localparam int TIMEOUT_CYCLES  = 200000;
	localparam int HOLD_CYCLES     = 150;
	localparam int PHASES          = 9;
	localparam int TICKS_PER_PHASE = 50;
	localparam int IDLE_PCT        = 37;

	// phases with a special role
	localparam int PHASE_DIRECTED = 0;
	localparam int PHASE_PRESSURE = 2;
	localparam int PHASE_PAUSE    = 3;
	localparam int PHASE_NO_IDLE  = 4;

	// manual command codes beyond open and close
	localparam logic [1:0] CMD_KEEP = 2'd2;
	localparam logic [1:0] CMD_ODD  = 2'd3;

	// status flag bits in tick order: pump, fault, alkali low, acid low, manual, link
	localparam logic [5:0] FL_PUMP = 6'b100000;
	localparam logic [5:0] FL_ERR  = 6'b010000;
	localparam logic [5:0] FL_ALK  = 6'b001000;
	localparam logic [5:0] FL_ACID = 6'b000100;
	localparam logic [5:0] FL_MAN  = 6'b000010;
	localparam logic [5:0] FL_LINK = 6'b000001;
	localparam logic [5:0] FL_RUN  = 6'b100001;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	hdvc_pkg::in_item_t              tick;
	logic                            out_valid;
	logic                            out_ready;
	logic                            raise_valve_on;
	logic                            lower_valve_on;
	logic [1:0]                      control_mode;
	logic                            pulse_open_phase;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [hdvc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [hdvc_pkg::CFG_DATA_W-1:0] cfg_data;
	int                              fail_count;
	int                              pending;

	hdvc_pkg::cfg_t cur_cfg;
	int   tx_idle;
	int   rx_idle;
	int   hold_reqs;
	int   holds_done;
	int   level;
	int   man_run;
	int   cycles = 0;

	hysteresis_dosing_valve_controller_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.ph_value         (tick.ph_value),
		.pump_on          (tick.pump_on),
		.sensor_error     (tick.sensor_error),
		.alkali_tank_low  (tick.alkali_tank_low),
		.acid_tank_low    (tick.acid_tank_low),
		.manual_request   (tick.manual_request),
		.link_up          (tick.link_up),
		.manual_raise_cmd (tick.manual_raise_cmd),
		.manual_lower_cmd (tick.manual_lower_cmd),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.raise_valve_on   (raise_valve_on),
		.lower_valve_on   (lower_valve_on),
		.control_mode     (control_mode),
		.pulse_open_phase (pulse_open_phase),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	hdvc_valve_checker u_valve_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.tick       (tick),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result     ({raise_valve_on, lower_valve_on, control_mode, pulse_open_phase}),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int held;
		out_ready  = 1'b0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (holds_done != hold_reqs) begin
				out_ready = 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++)
					@(negedge clk);
				holds_done = holds_done + 1;
			end else begin
				out_ready = ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// offer one tick after a random gap and hold it until the transfer
	task automatic drive_tick(input hdvc_pkg::in_item_t t);
		while ($urandom_range(99) < tx_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		tick     = t;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic wait_drained();
		in_valid = 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
		@(negedge clk);
	endtask

	// one register write; valid stays up for back-to-back writes
	task automatic write_reg(input logic [hdvc_pkg::CFG_IDX_W-1:0] idx,
		input logic [hdvc_pkg::CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	initial begin
		hdvc_pkg::cfg_t     plan;
		hdvc_pkg::in_item_t nt;
		int       p;
		int       half;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		tick      = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		tx_idle   = IDLE_PCT;
		rx_idle   = IDLE_PCT;
		hold_reqs = 0;
		level     = 6000;
		man_run   = 0;
		cur_cfg   = {hdvc_pkg::LOW_LIMIT_RST, hdvc_pkg::HIGH_LIMIT_RST,
			hdvc_pkg::HYST_WIDTH_RST, hdvc_pkg::OPEN_MS_RST, hdvc_pkg::CLOSE_MS_RST};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		for (p = 0; p < PHASES; p++) begin
			// pick the settings of this phase, extremes first
			case (p)
				0: plan = {14'd5000, 14'd7000, 11'd250, 16'd2, 16'd3};
				1: plan = {14'd14000, 14'd0, 11'd0, 16'd1, 16'd1};
				2: plan = {14'd0, 14'd12000, 11'd2000, 16'd1, 16'd2};
				3: plan = {14'd4000, 14'd9000, 11'd1001, 16'd0, 16'd0};
				4: plan = {14'd6000, 14'd8000, 11'd11, 16'd60000, 16'd60000};
				5: plan = {14'd7000, 14'd7000, 11'd3, 16'd5, 16'd7};
				default: begin
					plan.low_limit  = 14'($urandom_range(14000));
					plan.high_limit = 14'($urandom_range(14000));
					plan.hyst_width = 11'($urandom_range(2000));
					plan.open_ms    = 16'($urandom_range(1, 6));
					plan.close_ms   = 16'($urandom_range(1, 6));
				end
			endcase

			// settings change only while nothing is in flight
			wait_drained();
			write_reg(hdvc_pkg::REG_LOW_LIMIT, hdvc_pkg::CFG_DATA_W'(plan.low_limit));
			write_reg(hdvc_pkg::REG_HIGH_LIMIT, hdvc_pkg::CFG_DATA_W'(plan.high_limit));
			write_reg(hdvc_pkg::REG_HYST_WIDTH, hdvc_pkg::CFG_DATA_W'(plan.hyst_width));
			write_reg(hdvc_pkg::REG_OPEN_MS, plan.open_ms);
			write_reg(hdvc_pkg::REG_CLOSE_MS, plan.close_ms);
			cfg_valid = 1'b0;
			cur_cfg   = plan;
			tx_idle   = IDLE_PCT;
			rx_idle   = IDLE_PCT;

			if (p == PHASE_DIRECTED) begin
				// low dosing through two open and three closed ticks, ended by a low alkali tank
				repeat (5) drive_tick({14'd0, FL_RUN, CMD_KEEP, CMD_KEEP});
				drive_tick({14'd0, FL_RUN | FL_ALK, CMD_KEEP, CMD_KEEP});
				// high dosing ended by a reverse crossing
				repeat (4) drive_tick({14'd14000, FL_RUN, CMD_KEEP, CMD_KEEP});
				drive_tick({14'd6000, FL_RUN, CMD_KEEP, CMD_KEEP});
				// entry refused: acid tank low, pump off, sensor fault
				drive_tick({14'd14000, FL_RUN | FL_ACID, CMD_KEEP, CMD_KEEP});
				drive_tick({14'd14000, FL_LINK, CMD_KEEP, CMD_KEEP});
				drive_tick({14'd0, FL_RUN | FL_ERR, CMD_KEEP, CMD_KEEP});
				// low dosing ended by a reverse crossing
				drive_tick({14'd0, FL_RUN, CMD_KEEP, CMD_KEEP});
				drive_tick({14'd5200, FL_RUN, CMD_KEEP, CMD_KEEP});
				// manual taken during dosing, all commands, left on link loss
				drive_tick({14'd0, FL_RUN, CMD_KEEP, CMD_KEEP});
				drive_tick({14'd0, FL_RUN | FL_MAN, hdvc_pkg::CMD_OPEN, hdvc_pkg::CMD_OPEN});
				drive_tick({14'd0, FL_RUN | FL_MAN, hdvc_pkg::CMD_OPEN, hdvc_pkg::CMD_OPEN});
				drive_tick({14'd0, FL_RUN | FL_MAN, CMD_KEEP, hdvc_pkg::CMD_CLOSE});
				drive_tick({14'd0, FL_RUN | FL_MAN, CMD_ODD, CMD_ODD});
				drive_tick({14'd0, FL_PUMP | FL_MAN, hdvc_pkg::CMD_OPEN, hdvc_pkg::CMD_OPEN});
				// manual again, left when the request drops
				drive_tick({14'd8191, FL_RUN | FL_MAN, hdvc_pkg::CMD_CLOSE,
					hdvc_pkg::CMD_OPEN});
				drive_tick({14'd8191, FL_RUN | FL_MAN, hdvc_pkg::CMD_OPEN,
					hdvc_pkg::CMD_CLOSE});
				drive_tick({14'd8191, FL_RUN, CMD_KEEP, CMD_KEEP});
				drive_tick({14'd14000, FL_RUN | FL_ERR | FL_ALK | FL_ACID, CMD_ODD, CMD_ODD});
			end else if (p == PHASE_PRESSURE) begin
				// receiver holds off while ticks keep coming, so the block backs up
				tx_idle   = 0;
				hold_reqs = hold_reqs + 1;
			end else if (p == PHASE_NO_IDLE) begin
				tx_idle = 0;
				rx_idle = 0;
			end

			for (int i = 0; i < TICKS_PER_PHASE; i++) begin
				if (p == PHASE_PAUSE && i == TICKS_PER_PHASE / 2)
					wait_drained();

				// level: mostly held, otherwise near an entry or exit edge or anywhere in range
				half = int'(cur_cfg.hyst_width >> 1);
				if ($urandom_range(99) >= 55) begin
					case ($urandom_range(9))
						0, 1: level = int'(cur_cfg.low_limit) - half
							- int'($urandom_range(1, 40));
						2, 3: level = int'(cur_cfg.high_limit) + half
							+ int'($urandom_range(1, 40));
						4: level = int'(cur_cfg.low_limit) + half
							+ int'($urandom_range(2)) - 1;
						5: level = int'(cur_cfg.high_limit) - half
							+ int'($urandom_range(2)) - 1;
						6: level = int'(cur_cfg.low_limit) - half
							+ int'($urandom_range(2)) - 1;
						7: level = int'(cur_cfg.high_limit) + half
							+ int'($urandom_range(2)) - 1;
						default: level = int'($urandom_range(14000));
					endcase
					if (level < 0)
						level = 0;
					if (level > 14000)
						level = 14000;
				end
				nt.ph_value        = 14'(level);
				nt.pump_on         = ($urandom_range(99) >= 4);
				nt.sensor_error    = ($urandom_range(99) < 3);
				nt.alkali_tank_low = ($urandom_range(99) < 3);
				nt.acid_tank_low   = ($urandom_range(99) < 3);

				// manual runs of a few ticks, sometimes cut short by link loss
				if (man_run > 0) begin
					nt.manual_request = 1'b1;
					nt.link_up        = ($urandom_range(99) >= 8);
					man_run           = man_run - 1;
				end else begin
					nt.manual_request = ($urandom_range(99) < 4);
					nt.link_up        = ($urandom_range(99) >= 10);
					if (nt.manual_request)
						man_run = $urandom_range(1, 8);
				end
				nt.manual_raise_cmd = 2'($urandom_range(3));
				nt.manual_lower_cmd = 2'($urandom_range(3));
				drive_tick(nt);
			end
		end

		wait_drained();
		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
